### rtl/pcwrl_pkg.sv
// Package: shared types and constants for the per-client window rate limiter.
package pcwrl_pkg;

   localparam int DEFAULT_CLIENTS = 16;

   localparam int ADDR_W   = 32;
   localparam int TIME_W   = 32;
   localparam int TOKEN_W  = 8;
   localparam int WINDOW_W = 16;
   localparam int ENTRY_W  = ADDR_W + TOKEN_W + TIME_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_LIMIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS = 1'd1;

   localparam logic [TOKEN_W-1:0]  RESET_TOKEN_LIMIT    = 8'd5;
   localparam logic [WINDOW_W-1:0] RESET_WINDOW_SECONDS = 16'd10;

   typedef enum logic [1:0] {
      VERDICT_ALLOWED = 2'd0,
      VERDICT_LIMITED = 2'd1,
      VERDICT_NOROOM  = 2'd2,
      VERDICT_BYPASS  = 2'd3
   } verdict_type;

   typedef struct packed {
      logic        req_ready;
      logic        capture;
      logic        rd_en;
      logic        idx_inc;
      logic        alloc;
      logic        wr_en;
      logic        load_update;
      logic        load_fixed;
      verdict_type fixed_verdict;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_skip;
      logic empty;
      logic match;
      logic idx_last;
      logic full;
      logic rsp_free;
   } ctl_status_type;

endpackage

### rtl/pcwrl_if.sv
// Interfaces: request and response channels of the rate limiter.
interface pcwrl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] client_ip;
   logic [31:0] now_seconds;
   logic        skip_check;

   modport source (output valid, client_ip, now_seconds, skip_check, input ready);
   modport sink   (input valid, client_ip, now_seconds, skip_check, output ready);
endinterface

interface pcwrl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic [7:0] tokens_left;

   modport source (output valid, verdict, tokens_left, input ready);
   modport sink   (input valid, verdict, tokens_left, output ready);
endinterface

### rtl/pcwrl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcwrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/pcwrl_ctrl.sv
// Controller: sequences capture, table scan, update and response load.
module pcwrl_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  pcwrl_pkg::ctl_status_type   status,
   output pcwrl_pkg::ctl_cmd_type      cmd
);
   import pcwrl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_UPD,
      ST_FIXED
   } state_type;

   state_type   state_ff, state_in;
   verdict_type fixed_ff, fixed_in;

   always_comb begin
      state_in = state_ff;
      fixed_in = fixed_ff;
      cmd      = '0;
      cmd.fixed_verdict = fixed_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.capture = 1'b1;
               if (status.req_skip) begin
                  fixed_in = VERDICT_BYPASS;
                  state_in = ST_FIXED;
               end else if (status.empty) begin
                  cmd.alloc = 1'b1;
                  state_in  = ST_UPD;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            if (status.match) begin
               state_in = ST_UPD;
            end else if (status.idx_last) begin
               if (status.full) begin
                  fixed_in = VERDICT_NOROOM;
                  state_in = ST_FIXED;
               end else begin
                  cmd.alloc = 1'b1;
                  state_in  = ST_UPD;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_UPD: begin
            if (status.rsp_free) begin
               cmd.wr_en       = 1'b1;
               cmd.load_update = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_FIXED: begin
            if (status.rsp_free) begin
               cmd.load_fixed = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fixed_ff <= VERDICT_BYPASS;
      end else begin
         state_ff <= state_in;
         fixed_ff <= fixed_in;
      end
   end
endmodule

### rtl/pcwrl_dpath.sv
// Datapath: request capture, client table, token update, config and response registers.
module pcwrl_dpath #(
   parameter int CLIENTS = pcwrl_pkg::DEFAULT_CLIENTS
) (
   input  logic                                clock,
   input  logic                                reset,
   pcwrl_req_if.sink                           req,
   pcwrl_rsp_if.source                         rsp,
   input  logic                                csr_we,
   input  logic [pcwrl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcwrl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  pcwrl_pkg::ctl_cmd_type              cmd,
   output pcwrl_pkg::ctl_status_type           status
);
   import pcwrl_pkg::*;

   localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
   localparam int CNT_W = $clog2(CLIENTS + 1);

   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                alloc_ff, alloc_in;
   logic [TOKEN_W-1:0]  token_limit_ff, token_limit_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic                rsp_valid_ff, rsp_valid_in;
   verdict_type         verdict_ff, verdict_in;
   logic [TOKEN_W-1:0]  tokens_ff, tokens_in;

   logic [ENTRY_W-1:0]  rd_data;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ADDR_W-1:0]   rd_key;
   logic [TOKEN_W-1:0]  rd_tokens;
   logic [TIME_W-1:0]   rd_start;
   logic [TIME_W-1:0]   elapsed;
   logic                refill;
   logic [TOKEN_W-1:0]  base_tokens;
   logic                allowed;
   logic [TOKEN_W-1:0]  new_tokens;
   logic [TIME_W-1:0]   new_start;

   pcwrl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CLIENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_key    = rd_data[ENTRY_W-1 -: ADDR_W];
   assign rd_tokens = rd_data[TIME_W +: TOKEN_W];
   assign rd_start  = rd_data[TIME_W-1:0];

   assign elapsed     = now_ff - rd_start;
   assign refill      = alloc_ff || (elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, window_ff});
   assign base_tokens = refill ? token_limit_ff : rd_tokens;
   assign allowed     = (base_tokens != '0);
   assign new_tokens  = allowed ? base_tokens - 1'b1 : base_tokens;
   assign new_start   = refill ? now_ff : rd_start;
   assign wr_data     = {addr_ff, new_tokens, new_start};

   assign status.req_valid = req.valid;
   assign status.req_skip  = req.skip_check;
   assign status.empty     = (count_ff == '0);
   assign status.match     = (rd_key == addr_ff);
   assign status.idx_last  = ({1'b0, CNT_W'(idx_ff)} + 1'b1) == {1'b0, count_ff};
   assign status.full      = (count_ff == CNT_W'(CLIENTS));
   assign status.rsp_free  = !rsp_valid_ff || rsp.ready;

   assign req.ready       = cmd.req_ready;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.verdict     = verdict_ff;
   assign rsp.tokens_left = tokens_ff;

   always_comb begin
      addr_in        = addr_ff;
      now_in         = now_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      alloc_in       = alloc_ff;
      token_limit_in = token_limit_ff;
      window_in      = window_ff;
      rsp_valid_in   = rsp_valid_ff;
      verdict_in     = verdict_ff;
      tokens_in      = tokens_ff;

      if (cmd.capture) begin
         addr_in  = req.client_ip;
         now_in   = req.now_seconds;
         idx_in   = '0;
         alloc_in = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.alloc) begin
         idx_in   = count_ff[IDX_W-1:0];
         alloc_in = 1'b1;
      end
      if (cmd.wr_en && alloc_ff) begin
         count_in = count_ff + 1'b1;
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_update) begin
         rsp_valid_in = 1'b1;
         verdict_in   = allowed ? VERDICT_ALLOWED : VERDICT_LIMITED;
         tokens_in    = new_tokens;
      end
      if (cmd.load_fixed) begin
         rsp_valid_in = 1'b1;
         verdict_in   = cmd.fixed_verdict;
         tokens_in    = '0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_TOKEN_LIMIT:    token_limit_in = csr_wdata[TOKEN_W-1:0];
            CSR_WINDOW_SECONDS: window_in      = csr_wdata[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      now_ff     <= now_in;
      idx_ff     <= idx_in;
      verdict_ff <= verdict_in;
      tokens_ff  <= tokens_in;
      if (reset) begin
         count_ff       <= '0;
         alloc_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         token_limit_ff <= RESET_TOKEN_LIMIT;
         window_ff      <= RESET_WINDOW_SECONDS;
      end else begin
         count_ff       <= count_in;
         alloc_ff       <= alloc_in;
         rsp_valid_ff   <= rsp_valid_in;
         token_limit_ff <= token_limit_in;
         window_ff      <= window_in;
      end
   end
endmodule

### rtl/per_client_window_rate_limiter.sv
// Top level: per-client fixed-window rate limiter.
// Each request transaction looks its client address up in a table of CLIENTS
// entries held in one RAM with a single registered read port. The table is
// searched linearly, one entry at a time (a read state, then a compare
// state), until the client matches or the last filled entry is passed; a
// new client then takes the next free entry unless the table is full. An
// empty table skips the search and a bypassed request skips the table. The
// table write and response load wait for a free output register. Entries
// fill from the bottom and are never evicted, so a fill count stands in for
// valid bits and no clearing pass is needed after reset. A finished response
// waits in an output register while the next request is accepted. Registers: index 0
// token_limit (8 bits), index 1 window_seconds (16 bits); write only while idle.
module per_client_window_rate_limiter #(
   parameter int CLIENTS = pcwrl_pkg::DEFAULT_CLIENTS
) (
   input  logic                              clock,
   input  logic                              reset,
   pcwrl_req_if.sink                         req,
   pcwrl_rsp_if.source                       rsp,
   input  logic                              csr_we,
   input  logic [pcwrl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcwrl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pcwrl_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   pcwrl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   pcwrl_dpath #(
      .CLIENTS (CLIENTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );
endmodule
